// ===== rtl/core/bcw_pkg.sv =====
// ----------------------------------------------------------------------------
// bcw_pkg
// Shared types and constants of the block chain walker: item layout, command
// codes, stop causes, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package bcw_pkg;

  // Input item layout in in_tdata (lowest bit first)
  localparam int IN_CMD_W     = 2;
  localparam int IN_IDX_W     = 10;
  localparam int IN_VAL_W     = 32;
  localparam int IN_START_W   = 32;
  localparam int IN_CMD_LSB   = 0;
  localparam int IN_IDX_LSB   = IN_CMD_LSB + IN_CMD_W;
  localparam int IN_VAL_LSB   = IN_IDX_LSB + IN_IDX_W;
  localparam int IN_START_LSB = IN_VAL_LSB + IN_VAL_W;
  localparam int IN_BITS      = IN_START_LSB + IN_START_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

  // Result item layout
  localparam int BLK_W        = 10;
  localparam int OFF_W        = 20;
  localparam int OUT_BITS     = BLK_W + OFF_W;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;
  localparam int CAUSE_W      = 2;
  localparam int OUT_TUSER_W  = 1 + CAUSE_W;

  // Fixed block geometry
  localparam int SMALL_BLOCK_SHIFT = 6;   // small blocks are 64 bytes
  localparam int CHAIN_MAX         = 64;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int LIMIT_W    = 7;
  localparam int COUNT_W    = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_BLOCK     = 2'd0,
    CFG_SMALL_PRESENT = 2'd1,
    CFG_CHAIN_LIMIT   = 2'd2
  } cfg_reg_t;

  typedef enum logic [IN_CMD_W-1:0] {
    CMD_LOAD_BIG   = 2'd0,
    CMD_LOAD_SMALL = 2'd1,
    CMD_WALK_BIG   = 2'd2,
    CMD_WALK_SMALL = 2'd3
  } cmd_code_t;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_END    = 2'd0,
    CAUSE_LIMIT  = 2'd1,
    CAUSE_ABSENT = 2'd2
  } cause_t;

  // Controller -> datapath
  typedef struct packed {
    logic   accept;    // input item taken this cycle
    logic   capture;   // latch start block and table choice, clear count
    logic   advance;   // step to the next block of the chain
    logic   emit;      // load the result register
    logic   last;
    logic   empty;
    cause_t cause;
  } bcw_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_walk;       // pending input item is a walk
    logic start_ok;      // pending walk has a valid start block
    logic next_ok;       // table word read for the current block is valid
    logic small_absent;  // current walk is small and the small table is absent
    logic limit_hit;     // current block is the last allowed by the limit
    logic slot_free;     // result register can take a new item
  } bcw_status_t;

endpackage

// ===== rtl/core/block_chain_walker_core.sv =====
// ----------------------------------------------------------------------------
// block_chain_walker_core
// Walks block chains through a big-block and a small-block allocation table.
// ----------------------------------------------------------------------------
// A load is written to its table when accepted and the sequencer stays ready for the
// next item. A walk steps through ST_READ, where the table word of the current block
// is read into a register, and ST_EVAL, which loads the result register and waits
// while it is full. An invalid start gives its single result through ST_EMPTY. A new item
// is taken once the last result of the walk is in the output register.
// Reset (rst_n low, synchronous) clears the sequencer, the output valid and
// restores the configuration registers; table contents are kept.
// ----------------------------------------------------------------------------
module block_chain_walker_core import bcw_pkg::*; #(
  parameter int TABLE_ENTRIES   = 1024,
  parameter int BIG_BLOCK_BYTES = 512
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input items
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // cmd, entry_index, entry_value,
                                             // start_block, zero pad
  // Result items
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // block_number, byte_offset, zero pad
  output logic                   out_tlast,  // is_last
  output logic [OUT_TUSER_W-1:0] out_tuser,  // empty_chain, stop_cause
  // Configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  bcw_cmd_t    cmd;
  bcw_status_t status;

  // Registers can always take a write; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  // Sequencer: one state per table read and per result decision.
  bcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // Tables, cursor, offset arithmetic and the output register.
  bcw_datapath #(
    .TABLE_ENTRIES   (TABLE_ENTRIES),
    .BIG_BLOCK_BYTES (BIG_BLOCK_BYTES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== rtl/core/bcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// bcw_ctrl
// Walk sequencer: accepts items, steps the chain one table read at a time and
// decides the flags of every result.
// ----------------------------------------------------------------------------
module bcw_ctrl import bcw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  bcw_status_t status,
  output bcw_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_EMPTY
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd         = '0;
    cmd.cause   = CAUSE_END;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (status.in_walk) begin
            if (status.start_ok) begin
              cmd.capture = 1'b1;
              state_nxt   = ST_READ;
            end else begin
              state_nxt   = ST_EMPTY;
            end
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (status.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
          if (status.small_absent) begin
            cmd.cause = CAUSE_ABSENT;
          end else if (!status.next_ok) begin
            cmd.cause = CAUSE_END;
          end else if (status.limit_hit) begin
            cmd.cause = CAUSE_LIMIT;
          end else begin
            // chain continues: emit a middle result and fetch the next word
            cmd.last    = 1'b0;
            cmd.advance = 1'b1;
            state_nxt   = ST_READ;
          end
        end
      end
      ST_EMPTY: begin
        if (status.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.last  = 1'b1;
          cmd.empty = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/bcw_datapath.sv =====
// ----------------------------------------------------------------------------
// bcw_datapath
// Both allocation tables, configuration registers, the chain cursor and the
// result register.
// ----------------------------------------------------------------------------
module bcw_datapath import bcw_pkg::*; #(
  parameter int TABLE_ENTRIES   = 1024,
  parameter int BIG_BLOCK_BYTES = 512
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  bcw_cmd_t               cmd,
  output bcw_status_t            status,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  localparam int AW = $clog2(TABLE_ENTRIES);

  function automatic logic blk_ok(input logic [31:0] w, input logic [BLK_W-1:0] mx);
    blk_ok = (w <= 32'(mx)) && (w < 32'(TABLE_ENTRIES));
  endfunction

  // Input fields
  cmd_code_t         in_cmd;
  logic [IN_IDX_W-1:0]   in_idx;
  logic [IN_VAL_W-1:0]   in_val;
  logic [IN_START_W-1:0] in_start;

  assign in_cmd   = cmd_code_t'(in_tdata[IN_CMD_LSB +: IN_CMD_W]);
  assign in_idx   = in_tdata[IN_IDX_LSB +: IN_IDX_W];
  assign in_val   = in_tdata[IN_VAL_LSB +: IN_VAL_W];
  assign in_start = in_tdata[IN_START_LSB +: IN_START_W];

  // Configuration registers
  logic [BLK_W-1:0]   max_block_r;
  logic               small_present_r;
  logic [LIMIT_W-1:0] chain_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_block_r     <= BLK_W'(1023);
      small_present_r <= 1'b1;
      chain_limit_r   <= LIMIT_W'(CHAIN_MAX);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAX_BLOCK:     max_block_r     <= cfg_data[BLK_W-1:0];
        CFG_SMALL_PRESENT: small_present_r <= cfg_data[0];
        CFG_CHAIN_LIMIT:   chain_limit_r   <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Tables
  logic [31:0] big_mem   [TABLE_ENTRIES];
  logic [31:0] small_mem [TABLE_ENTRIES];
  logic [31:0] big_rd_r, small_rd_r;
  logic [BLK_W-1:0] cur_r;
  logic             small_r;
  logic [COUNT_W-1:0] count_r;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic             wr_ok;

  assign rd_addr = AW'(cur_r);
  assign wr_addr = AW'(in_idx);
  assign wr_ok   = cmd.accept && (32'(in_idx) < 32'(TABLE_ENTRIES));

  always_ff @(posedge clk) begin
    if (wr_ok && (in_cmd == CMD_LOAD_BIG)) begin
      big_mem[wr_addr] <= in_val;
    end
    big_rd_r <= big_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_ok && (in_cmd == CMD_LOAD_SMALL)) begin
      small_mem[wr_addr] <= in_val;
    end
    small_rd_r <= small_mem[rd_addr];
  end

  // Chain cursor
  logic [31:0] next_word;
  assign next_word = small_r ? small_rd_r : big_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.capture) begin
      count_r <= '0;
    end else if (cmd.advance) begin
      count_r <= count_r + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_r   <= in_start[BLK_W-1:0];
      small_r <= (in_cmd == CMD_WALK_SMALL);
    end else if (cmd.advance) begin
      cur_r   <= next_word[BLK_W-1:0];
    end
  end

  // Effective limit: zero acts as one, saturate at the result cap
  logic [LIMIT_W-1:0] limit_eff;
  always_comb begin
    limit_eff = chain_limit_r;
    if (chain_limit_r == '0) begin
      limit_eff = LIMIT_W'(1);
    end else if (chain_limit_r > LIMIT_W'(CHAIN_MAX)) begin
      limit_eff = LIMIT_W'(CHAIN_MAX);
    end
  end

  assign status.in_walk      = (in_cmd == CMD_WALK_BIG) || (in_cmd == CMD_WALK_SMALL);
  assign status.start_ok     = blk_ok(in_start, max_block_r);
  assign status.next_ok      = blk_ok(next_word, max_block_r);
  assign status.small_absent = small_r && !small_present_r;
  assign status.limit_hit    = ((LIMIT_W'(count_r) + LIMIT_W'(1)) >= limit_eff);
  assign status.slot_free    = !out_tvalid || out_tready;

  // Byte offset of the current block
  logic [OFF_W-1:0] off;
  always_comb begin
    if (small_r) begin
      off = OFF_W'({cur_r, {SMALL_BLOCK_SHIFT{1'b0}}});
    end else begin
      off = OFF_W'((32'(cur_r) + 32'd1) * 32'(BIG_BLOCK_BYTES));
    end
  end

  // Result register
  logic             out_valid_r;
  logic [BLK_W-1:0] out_blk_r;
  logic [OFF_W-1:0] out_off_r;
  logic             out_last_r;
  logic             out_empty_r;
  cause_t           out_cause_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_blk_r   <= cmd.empty ? '0 : cur_r;
      out_off_r   <= cmd.empty ? '0 : off;
      out_last_r  <= cmd.last;
      out_empty_r <= cmd.empty;
      out_cause_r <= cmd.cause;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_off_r, out_blk_r});
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_cause_r, out_empty_r};

endmodule
